// ----- hdl/alirf_pkg.sv -----
`timescale 1ns / 1ps
// alirf_pkg: command and status codes, field widths and the result struct
// shared by the array list core and its sequencer; no dependencies
package alirf_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FPOS_W  = 6;
    localparam int COUNT_W = 7;

    // packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    // one result word
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FPOS_W-1:0]  found_position;
        logic [STAT_W-1:0]  status;
    } res_t;

endpackage

// ----- hdl/array_list_insert_remove_find_core.sv -----
`timescale 1ns / 1ps
// Ordered list of signed 32-bit words: insert, remove and find commands.
// Commands enter on the s_ stream, one result word per command leaves on m_.
// Usage notes:
//   s_tdata carries command, position and data_value; m_tdata carries
//   status, found_position and count (the list length after the command).
//   Each command that passes its checks walks the entry memory through one
//   shared step and compare unit, one entry per cycle, since the memory has
//   a single read and a single write port.
//   Insert moves the entries from the end down to the position up by one,
//   then writes the value; remove moves the entries above the position down
//   by one; find reads from entry 0 up to the first match or the end; errors
//   and the unused command go straight to the result.
//   s_tready is high only while no command is in progress; the next command
//   can be taken in the cycle after the result moves into the output register.
//   If the receiver stalls, the result waits in the output register; the
//   sequencer finishes the following command and holds it until that
//   register frees.
//   Reset (aresetn low, synchronous) empties the list; no clearing pass
//   is needed since entries at or above the length are never read.
// Depends on alirf_pkg, alirf_seq, alirf_unit and alirf_ram.
module array_list_insert_remove_find_core #(
    parameter int CAPACITY = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command [1:0], position [8:2], data_value [40:9], zero [47:41]
    input  logic [alirf_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [1:0], found_position [7:2], count [14:8], zero [15]
    output logic [alirf_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int AW = $clog2(CAPACITY);

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [alirf_pkg::DATA_W-1:0]  ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [alirf_pkg::DATA_W-1:0]  ram_rdata;
    logic                          res_valid;
    logic                          res_ready;
    alirf_pkg::res_t               res;

    logic                          m_tvalid_reg, m_tvalid_next;
    alirf_pkg::res_t               m_res_reg, m_res_next;

    // sequencer
    alirf_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[1:0]),
        .in_pos    (s_tdata[8:2]),
        .in_val    (s_tdata[40:9]),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // entry storage
    alirf_ram #(
        .CAPACITY (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg};

endmodule

// ----- hdl/alirf_ram.sv -----
`timescale 1ns / 1ps
// alirf_ram: entry storage, one write port and one read port with
// registered read data; uses alirf_pkg for the data width
module alirf_ram #(
    parameter int CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(CAPACITY)-1:0]  waddr,
    input  logic [alirf_pkg::DATA_W-1:0] wdata,
    input  logic                         re,
    input  logic [$clog2(CAPACITY)-1:0]  raddr,
    output logic [alirf_pkg::DATA_W-1:0] rdata
);

    logic [alirf_pkg::DATA_W-1:0] mem [CAPACITY];
    logic [alirf_pkg::DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/alirf_unit.sv -----
`timescale 1ns / 1ps
// alirf_unit: shared step unit of the sequencer, index step up or down
// and the equality compare of a read entry; uses alirf_pkg
module alirf_unit #(
    parameter int LW = 7
) (
    input  logic [LW-1:0]                idx,
    input  logic                         up,
    input  logic [alirf_pkg::DATA_W-1:0] a,
    input  logic [alirf_pkg::DATA_W-1:0] b,
    output logic [LW-1:0]                idx_step,
    output logic                         equal
);

    localparam logic [LW-1:0] ONE = LW'(1);

    // index step
    assign idx_step = up ? (idx + ONE) : (idx - ONE);

    // entry compare
    assign equal = (a == b);

endmodule

// ----- hdl/alirf_seq.sv -----
`timescale 1ns / 1ps
// alirf_seq: command sequencer with the length counter; walks the entry
// memory one entry per cycle through alirf_unit; uses alirf_pkg
module alirf_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [alirf_pkg::CMD_W-1:0]   in_cmd,
    input  logic [alirf_pkg::POS_W-1:0]   in_pos,
    input  logic [alirf_pkg::DATA_W-1:0]  in_val,
    // memory side
    output logic                          ram_we,
    output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
    output logic [alirf_pkg::DATA_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(CAPACITY)-1:0]   ram_raddr,
    input  logic [alirf_pkg::DATA_W-1:0]  ram_rdata,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output alirf_pkg::res_t               res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > alirf_pkg::POS_W) ? LW : alirf_pkg::POS_W;
    localparam logic [LW-1:0] ONE_L = LW'(1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [alirf_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [alirf_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [alirf_pkg::DATA_W-1:0]    val_reg, val_next;
    logic [LW-1:0]                   len_reg, len_next;
    logic [LW-1:0]                   idx_reg, idx_next;
    logic                            pend_reg, pend_next;
    logic [AW-1:0]                   pend_addr_reg, pend_addr_next;
    logic [alirf_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [AW-1:0]                   where_reg, where_next;

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] where_ext;
    logic [LW-1:0] idx_step;
    logic          step_up;
    logic          equal;

    assign pos_ext   = CW'(pos_reg);
    assign len_ext   = CW'(len_reg);
    assign idx_ext   = CW'(idx_reg);
    assign where_ext = CW'(where_reg);
    assign step_up   = (cmd_reg != alirf_pkg::CMD_INSERT);

    // shared step and compare unit
    alirf_unit #(
        .LW (LW)
    ) u_unit (
        .idx      (idx_reg),
        .up       (step_up),
        .a        (ram_rdata),
        .b        (val_reg),
        .idx_step (idx_step),
        .equal    (equal)
    );

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        where_next     = where_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    pos_next   = in_pos;
                    val_next   = in_val;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                where_next  = '0;
                pend_next   = 1'b0;
                status_next = alirf_pkg::ST_OK;
                case (cmd_reg)
                    alirf_pkg::CMD_INSERT: begin
                        idx_next = len_reg;
                        if (pos_ext > len_ext) begin
                            status_next = alirf_pkg::ST_RANGE;
                            state_next  = S_FIN;
                        end else if (len_ext >= CAP_C) begin
                            status_next = alirf_pkg::ST_FULL;
                            state_next  = S_FIN;
                        end else begin
                            state_next = S_RUN;
                        end
                    end
                    alirf_pkg::CMD_REMOVE: begin
                        idx_next = pos_ext[LW-1:0];
                        if (pos_ext >= len_ext) begin
                            status_next = alirf_pkg::ST_RANGE;
                            state_next  = S_FIN;
                        end else begin
                            state_next = S_RUN;
                        end
                    end
                    alirf_pkg::CMD_FIND: begin
                        idx_next   = '0;
                        state_next = S_RUN;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RUN: begin
                pend_next = 1'b0;
                case (cmd_reg)
                    alirf_pkg::CMD_INSERT: begin
                        // move entry idx-1 up to idx, then drop the value in
                        ram_we = pend_reg;
                        if (idx_ext > pos_ext) begin
                            ram_re         = 1'b1;
                            ram_raddr      = idx_step[AW-1:0];
                            pend_next      = 1'b1;
                            pend_addr_next = idx_reg[AW-1:0];
                            idx_next       = idx_step;
                        end else if (!pend_reg) begin
                            ram_we      = 1'b1;
                            ram_waddr   = pos_ext[AW-1:0];
                            ram_wdata   = val_reg;
                            len_next    = len_reg + ONE_L;
                            status_next = alirf_pkg::ST_OK;
                            state_next  = S_FIN;
                        end
                    end
                    alirf_pkg::CMD_REMOVE: begin
                        // move entry idx+1 down to idx
                        ram_we = pend_reg;
                        if (idx_step < len_reg) begin
                            ram_re         = 1'b1;
                            ram_raddr      = idx_step[AW-1:0];
                            pend_next      = 1'b1;
                            pend_addr_next = idx_reg[AW-1:0];
                            idx_next       = idx_step;
                        end else if (!pend_reg) begin
                            len_next    = len_reg - ONE_L;
                            status_next = alirf_pkg::ST_OK;
                            state_next  = S_FIN;
                        end
                    end
                    default: begin
                        // find: read ahead one entry, compare the last one read
                        if (pend_reg && equal) begin
                            status_next = alirf_pkg::ST_OK;
                            where_next  = pend_addr_reg;
                            state_next  = S_FIN;
                        end else if (idx_reg < len_reg) begin
                            ram_re         = 1'b1;
                            ram_raddr      = idx_reg[AW-1:0];
                            pend_next      = 1'b1;
                            pend_addr_next = idx_reg[AW-1:0];
                            idx_next       = idx_step;
                        end else if (!pend_reg) begin
                            status_next = alirf_pkg::ST_MISS;
                            state_next  = S_FIN;
                        end
                    end
                endcase
            end
            S_FIN: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        where_reg     <= where_next;
    end

    // result word
    always_comb begin
        res.status         = status_reg;
        res.found_position = where_ext[alirf_pkg::FPOS_W-1:0];
        res.count          = len_ext[alirf_pkg::COUNT_W-1:0];
    end

endmodule

// ----- bench/alirf_checker.sv -----
`timescale 1ns / 1ps
// alirf_checker: watches both streams of the array list core, keeps its own
// copy of the list and compares every result word; depends on alirf_pkg
module alirf_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [alirf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [alirf_pkg::M_TDATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              pending
);

    localparam int POS_LO = alirf_pkg::CMD_W;
    localparam int VAL_LO = alirf_pkg::CMD_W + alirf_pkg::POS_W;
    localparam int VAL_HI = VAL_LO + alirf_pkg::DATA_W - 1;
    localparam int RES_W  = alirf_pkg::COUNT_W + alirf_pkg::FPOS_W + alirf_pkg::STAT_W;

    // shadow copy of the list
    logic [alirf_pkg::DATA_W-1:0] list_words [CAPACITY];
    int unsigned                  list_len;

    // results still owed by the core, oldest first
    alirf_pkg::res_t owed_results [$];

    // apply one command to the shadow list and return the result word
    function automatic alirf_pkg::res_t list_apply(
        input logic [alirf_pkg::CMD_W-1:0]  cmd,
        input logic [alirf_pkg::POS_W-1:0]  pos,
        input logic [alirf_pkg::DATA_W-1:0] val);
        alirf_pkg::res_t r;
        int unsigned     p;
        bit              hit;
        p   = 32'(pos);
        hit = 1'b0;
        r.status         = alirf_pkg::ST_OK;
        r.found_position = '0;
        case (cmd)
            alirf_pkg::CMD_INSERT: begin
                if (p > list_len) begin
                    r.status = alirf_pkg::ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    r.status = alirf_pkg::ST_FULL;
                end else begin
                    for (int i = int'(list_len); i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val;
                    list_len++;
                end
            end
            alirf_pkg::CMD_REMOVE: begin
                if (p >= list_len) begin
                    r.status = alirf_pkg::ST_RANGE;
                end else begin
                    for (int i = int'(p); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            alirf_pkg::CMD_FIND: begin
                // first match wins
                for (int i = 0; i < list_len; i++) begin
                    if (!hit && list_words[i] == val) begin
                        hit = 1'b1;
                        r.found_position = i[alirf_pkg::FPOS_W-1:0];
                    end
                end
                if (!hit)
                    r.status = alirf_pkg::ST_MISS;
            end
            default: begin
                // unused command leaves the list alone
            end
        endcase
        r.count = list_len[alirf_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // compare results, then predict the newly accepted command
    always @(posedge aclk) begin
        alirf_pkg::res_t got;
        alirf_pkg::res_t want;
        int              errs;
        errs = 0;
        if (!aresetn) begin
            list_len = 0;
            owed_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = alirf_pkg::res_t'(m_tdata[RES_W-1:0]);
                if (owed_results.size() == 0) begin
                    $error("result word with nothing owed: %h", m_tdata);
                    errs++;
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, actual %0d",
                               want.found_position, got.found_position);
                        errs++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, got.count);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(list_apply(s_tdata[POS_LO-1:0],
                                                  s_tdata[VAL_LO-1:POS_LO],
                                                  s_tdata[VAL_HI:VAL_LO]));
            fail_count <= fail_count + errs;
            pending    <= owed_results.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: drives commands into the array list core and gives the verdict;
// depends on alirf_pkg, alirf_checker and the core itself
module tb_top;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_ITEMS  = 900;
    localparam int PHASE_LEN   = 60;
    localparam int CNT_LO      = alirf_pkg::STAT_W + alirf_pkg::FPOS_W;
    localparam int CNT_HI      = CNT_LO + alirf_pkg::COUNT_W - 1;
    localparam int PAD_W       = alirf_pkg::S_TDATA_W - alirf_pkg::CMD_W
                                 - alirf_pkg::POS_W - alirf_pkg::DATA_W;

    typedef logic [alirf_pkg::CMD_W-1:0]  cmd_t;
    typedef logic [alirf_pkg::POS_W-1:0]  pos_t;
    typedef logic [alirf_pkg::DATA_W-1:0] val_t;
    typedef enum logic [1:0] {PH_GROW, PH_MIX, PH_SHRINK} phase_t;

    localparam cmd_t CMD_UNUSED = 2'd3;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // command [1:0], position [8:2], data_value [40:9], zero [47:41]
    logic [alirf_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // status [1:0], found_position [7:2], count [14:8], zero [15]
    logic [alirf_pkg::M_TDATA_W-1:0] m_tdata;

    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    bit                   idle_on     = 1'b1;
    int unsigned          seen_len    = 0;
    val_t                 value_pool [$];

    always #4 aclk = ~aclk;

    array_list_insert_remove_find_core #(.CAPACITY(CAPACITY)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alirf_checker #(.CAPACITY(CAPACITY)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= idle_on ? ($urandom_range(99) >= 27) : 1'b1;

    // rough list length from the result words, used only to aim positions
    always @(posedge aclk)
        if (m_tvalid && m_tready)
            seen_len <= 32'(m_tdata[CNT_HI:CNT_LO]);

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // offer one word and hold it until taken
    task automatic send_word(input cmd_t cmd, input pos_t pos, input val_t val);
        while (idle_on && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, val, pos, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending until every owed result is back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // wide random values half the time, otherwise edge values or a small set to force duplicates
    function automatic val_t pick_value;
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // one random command, biased by the phase
    task automatic send_random(input phase_t phase);
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned rem_pct;
        int unsigned len;
        cmd_t        cmd;
        pos_t        pos;
        val_t        val;
        len  = (seen_len > CAPACITY) ? CAPACITY : seen_len;
        roll = $urandom_range(99);
        case (phase)
            PH_GROW:   begin ins_pct = 65; rem_pct = 15; end
            PH_SHRINK: begin ins_pct = 15; rem_pct = 65; end
            default:   begin ins_pct = 35; rem_pct = 30; end
        endcase
        val = pick_value();
        if (roll < 5) begin
            // noise: any command, any position
            cmd = cmd_t'($urandom_range(3));
            pos = pos_t'($urandom_range(127));
        end else if (roll < 5 + ins_pct) begin
            cmd = alirf_pkg::CMD_INSERT;
            case ($urandom_range(3))
                0: pos = '0;
                1: pos = pos_t'(len);
                default: pos = pos_t'($urandom_range(len));
            endcase
            value_pool.push_back(val);
            if (value_pool.size() > 24)
                void'(value_pool.pop_front());
        end else if (roll < 5 + ins_pct + rem_pct) begin
            cmd = alirf_pkg::CMD_REMOVE;
            pos = (len == 0) ? '0 : pos_t'($urandom_range(len - 1));
        end else begin
            cmd = alirf_pkg::CMD_FIND;
            pos = pos_t'($urandom_range(127));
            if (value_pool.size() > 0 && $urandom_range(99) < 70)
                val = value_pool[$urandom_range(value_pool.size() - 1)];
        end
        send_word(cmd, pos, val);
    endtask

    initial begin
        phase_t phase;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list errors, unused command, edge values
        send_word(alirf_pkg::CMD_REMOVE, 7'd0,   32'd0);
        send_word(alirf_pkg::CMD_FIND,   7'd0,   32'd0);
        send_word(alirf_pkg::CMD_INSERT, 7'd1,   32'd5);
        send_word(alirf_pkg::CMD_INSERT, 7'd127, 32'd5);
        send_word(CMD_UNUSED,            7'd0,   32'd0);
        send_word(alirf_pkg::CMD_INSERT, 7'd0,   32'h8000_0000);
        send_word(alirf_pkg::CMD_INSERT, 7'd1,   32'h7fff_ffff);
        send_word(alirf_pkg::CMD_INSERT, 7'd0,   32'h0000_0000);
        send_word(alirf_pkg::CMD_INSERT, 7'd1,   32'hffff_ffff);
        send_word(alirf_pkg::CMD_INSERT, 7'd2,   32'h7fff_ffff);
        send_word(alirf_pkg::CMD_FIND,   7'd0,   32'h7fff_ffff);
        send_word(alirf_pkg::CMD_FIND,   7'd127, 32'h8000_0000);
        send_word(alirf_pkg::CMD_FIND,   7'd0,   32'd12345);
        send_word(alirf_pkg::CMD_INSERT, 7'd6,   32'd1);
        send_word(alirf_pkg::CMD_REMOVE, 7'd4,   32'd0);
        send_word(alirf_pkg::CMD_REMOVE, 7'd0,   32'hffff_ffff);
        send_word(alirf_pkg::CMD_REMOVE, 7'd5,   32'd0);
        send_word(alirf_pkg::CMD_REMOVE, 7'd127, 32'd0);
        send_word(CMD_UNUSED,            7'd127, 32'hffff_ffff);
        send_word(alirf_pkg::CMD_FIND,   7'd0,   32'd0);
        send_word(alirf_pkg::CMD_REMOVE, 7'd0,   32'd0);
        send_word(alirf_pkg::CMD_REMOVE, 7'd0,   32'd0);
        send_word(alirf_pkg::CMD_REMOVE, 7'd0,   32'd0);
        send_word(alirf_pkg::CMD_FIND,   7'd0,   32'hffff_ffff);
        drain();

        // random: phases biased to grow, churn, shrink and churn, repeated
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ((n / PHASE_LEN) % 6)
                0, 1:    phase = PH_GROW;
                3, 4:    phase = PH_SHRINK;
                default: phase = PH_MIX;
            endcase
            idle_on = !(n >= 300 && n < 450);
            if (n == 500)
                drain();
            send_random(phase);
        end

        // wait out everything still owed, then idle before the verdict
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/alirf_pkg.sv
hdl/alirf_ram.sv
hdl/alirf_unit.sv
hdl/alirf_seq.sv
hdl/array_list_insert_remove_find_core.sv
bench/alirf_checker.sv
bench/tb_top.sv
